[hdl/ascii_unsigned_integer_parser_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ASCII unsigned integer parser
// Shared property shapes used by the parser's checker.
// ----------------------------------------------------------------------------
`ifndef ASCII_UNSIGNED_INTEGER_PARSER_TOP_MACROS_SVH
`define ASCII_UNSIGNED_INTEGER_PARSER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AUP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AUP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/aup_pkg.sv]
// ----------------------------------------------------------------------------
// aup_pkg
// Types and constants shared by the ASCII unsigned integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package aup_pkg;

  // Default width of the parsed value.
  localparam int VALUE_WIDTH_DEF = 64;

  // Character codes the parser recognizes.
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_X = 8'h78;
  localparam logic [7:0] CHAR_UPPER_X = 8'h58;

  // Value of the letter digits relative to their letter.
  localparam logic [7:0] LETTER_OFFSET = 8'd10;

  // Kept-character counter saturates at two.
  localparam logic [1:0] KEPT_NONE = 2'd0;
  localparam logic [1:0] KEPT_ONE  = 2'd1;
  localparam logic [1:0] KEPT_SAT  = 2'd2;

  // Queue between the classifier and the accumulator.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // One classified character as it travels through the queue.
  typedef struct packed {
    logic       blank;       // space or tab, skipped
    logic       is_x;        // 'x' or 'X'
    logic       is_zero;     // '0'
    logic       is_dec;      // '0' to '9'
    logic       is_letter;   // 'a' to 'f' or 'A' to 'F'
    logic [3:0] digit;       // digit value when is_dec or is_letter
    logic       last;        // final character of the string
  } char_class_t;

endpackage

`default_nettype wire

[hdl/aup_char_if.sv]
// ----------------------------------------------------------------------------
// aup_char_if
// Character channel: one ASCII character per item with a last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface aup_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink   (input valid, input character, input last_char, output ready);
endinterface

`default_nettype wire

[hdl/aup_result_if.sv]
// ----------------------------------------------------------------------------
// aup_result_if
// Result channel: the parsed value and its ok flag, one item per string.
// ----------------------------------------------------------------------------
`default_nettype none

interface aup_result_if #(
  parameter int VALUE_WIDTH = aup_pkg::VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] parsed_value;
  logic                   ok;

  modport source (output valid, output parsed_value, output ok, input ready);
  modport sink   (input valid, input parsed_value, input ok, output ready);
endinterface

`default_nettype wire

[hdl/aup_front.sv]
// ----------------------------------------------------------------------------
// aup_front
// Classifies each incoming character into blank, prefix letter and digit.
// ----------------------------------------------------------------------------
`default_nettype none

module aup_front (
  input  wire logic [7:0]           character,
  input  wire logic                 last_char,
  output aup_pkg::char_class_t      char_class
);
  import aup_pkg::*;

  logic is_lower;
  logic is_upper;

  // Range checks on the raw character code.
  assign is_lower = (character >= CHAR_LOWER_A) && (character <= CHAR_LOWER_F);
  assign is_upper = (character >= CHAR_UPPER_A) && (character <= CHAR_UPPER_F);

  // Build the class record. Validity against the base is decided later,
  // since the base is only known once the prefix has been seen.
  always_comb begin
    char_class.blank     = (character == CHAR_SPACE) || (character == CHAR_TAB);
    char_class.is_x      = (character == CHAR_LOWER_X) || (character == CHAR_UPPER_X);
    char_class.is_zero   = (character == CHAR_ZERO);
    char_class.is_dec    = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    char_class.is_letter = is_lower || is_upper;
    char_class.last      = last_char;
    if (is_lower) begin
      char_class.digit = 4'(character - CHAR_LOWER_A + LETTER_OFFSET);
    end else if (is_upper) begin
      char_class.digit = 4'(character - CHAR_UPPER_A + LETTER_OFFSET);
    end else begin
      char_class.digit = 4'(character - CHAR_ZERO);
    end
  end

endmodule

`default_nettype wire

[hdl/aup_queue.sv]
// ----------------------------------------------------------------------------
// aup_queue
// Short FIFO of classified characters between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module aup_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire aup_pkg::char_class_t push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      not_empty,
  output aup_pkg::char_class_t      head
);
  import aup_pkg::*;

  localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_PTR_W:0]   COUNT_FULL = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [QUEUE_PTR_W:0]   COUNT_ONE  = (QUEUE_PTR_W + 1)'(1);

  char_class_t              entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr;
  logic [QUEUE_PTR_W-1:0]   rd_ptr;
  logic [QUEUE_PTR_W:0]     count;
  logic                     do_push;
  logic                     do_pop;

  assign full      = (count == COUNT_FULL);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Storage of the queued items.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + COUNT_ONE;
      end else if (do_pop && !do_push) begin
        count <= count - COUNT_ONE;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/aup_back.sv]
// ----------------------------------------------------------------------------
// aup_back
// Applies classified characters to the parse state and registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module aup_back #(
  parameter int VALUE_WIDTH = aup_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   head_valid,
  input  wire aup_pkg::char_class_t   head,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [VALUE_WIDTH-1:0]      parsed_value,
  output logic                        ok
);
  import aup_pkg::*;

  localparam int SUM_W = VALUE_WIDTH + 4;

  // Parse state.
  logic [VALUE_WIDTH-1:0] accumulator;
  logic                   hex_mode;
  logic [1:0]             kept_count;
  logic                   first_was_zero;
  logic                   digit_seen;
  logic                   failed;

  logic [VALUE_WIDTH-1:0] accumulator_next;
  logic                   hex_mode_next;
  logic [1:0]             kept_count_next;
  logic                   first_was_zero_next;
  logic                   digit_seen_next;
  logic                   failed_next;

  logic [SUM_W-1:0]       product;
  logic [SUM_W-1:0]       sum;
  logic                   overflow;
  logic                   digit_ok;
  logic                   active;
  logic                   prefix_x;
  logic                   good;

  // A last item waits while the result register is still held.
  assign pop = head_valid && (!head.last || !out_valid || out_ready);

  // Multiply by the base with shifts, then add the digit and look for carry out.
  assign product  = hex_mode ? {head.digit & 4'h0, accumulator} << 4
                             : ({1'b0, accumulator, 3'b000} + {3'b000, accumulator, 1'b0});
  assign sum      = product + {{VALUE_WIDTH{1'b0}}, head.digit};
  assign overflow = |sum[SUM_W-1:VALUE_WIDTH];
  assign digit_ok = head.is_dec || (hex_mode && head.is_letter);
  assign active   = !head.blank && !failed;
  assign prefix_x = (kept_count == KEPT_ONE) && first_was_zero && head.is_x;

  // Next parse state for the item at the head of the queue.
  always_comb begin
    accumulator_next    = accumulator;
    hex_mode_next       = hex_mode;
    kept_count_next     = kept_count;
    first_was_zero_next = first_was_zero;
    digit_seen_next     = digit_seen;
    failed_next         = failed;
    if (active) begin
      if (prefix_x) begin
        hex_mode_next   = 1'b1;
        digit_seen_next = 1'b0;
      end else begin
        if ((kept_count == KEPT_NONE) && head.is_zero) begin
          first_was_zero_next = 1'b1;
        end
        if (!digit_ok || overflow) begin
          failed_next = 1'b1;
        end else begin
          accumulator_next = sum[VALUE_WIDTH-1:0];
          digit_seen_next  = 1'b1;
        end
      end
      if (kept_count != KEPT_SAT) begin
        kept_count_next = kept_count + 2'd1;
      end
    end
  end

  assign good = !failed_next && digit_seen_next;

  // State update; the final character returns everything to the start.
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator    <= '0;
      hex_mode       <= 1'b0;
      kept_count     <= KEPT_NONE;
      first_was_zero <= 1'b0;
      digit_seen     <= 1'b0;
      failed         <= 1'b0;
    end else if (pop) begin
      if (head.last) begin
        accumulator    <= '0;
        hex_mode       <= 1'b0;
        kept_count     <= KEPT_NONE;
        first_was_zero <= 1'b0;
        digit_seen     <= 1'b0;
        failed         <= 1'b0;
      end else begin
        accumulator    <= accumulator_next;
        hex_mode       <= hex_mode_next;
        kept_count     <= kept_count_next;
        first_was_zero <= first_was_zero_next;
        digit_seen     <= digit_seen_next;
        failed         <= failed_next;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; zero whenever the parse failed.
  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      parsed_value <= good ? accumulator_next : '0;
      ok           <= good;
    end
  end

endmodule

`default_nettype wire

[hdl/ascii_unsigned_integer_parser_top.sv]
// ----------------------------------------------------------------------------
// ascii_unsigned_integer_parser_top
// Parses a decimal or 0x-prefixed hexadecimal string into an unsigned value.
// ----------------------------------------------------------------------------
// Usage:
//   chars carries one ASCII character per item, with last_char set on the
//   final character of a string. Spaces and tabs are skipped anywhere.
//   result carries one item per string: parsed_value and ok. A failed parse
//   (bad character, overflow, no digit, bare prefix) gives ok = 0 and a zero
//   value.
// Timing:
//   The block takes one character per cycle while no result is held by the
//   receiver. A character is classified and written into a two-entry queue
//   on the accepting edge; the accumulator stage then takes it from the
//   queue, where the shift-add by ten or sixteen and its carry check are
//   combinational. result.valid is set as the accumulator stage takes the
//   last character of a string from the queue.
// Reset and stalls:
//   Reset empties the queue, clears the parse state and drops result.valid.
//   While result is held by the receiver, the next string's characters keep
//   flowing until its own last character reaches the accumulator stage;
//   then the queue fills and chars.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_unsigned_integer_parser_top #(
  parameter int VALUE_WIDTH = aup_pkg::VALUE_WIDTH_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  aup_char_if.sink     chars,
  aup_result_if.source result
);
  import aup_pkg::*;

  char_class_t char_class;
  char_class_t head;
  logic        queue_full;
  logic        head_valid;
  logic        pop;

  // Classifier.
  aup_front u_front (
    .character  (chars.character),
    .last_char  (chars.last_char),
    .char_class (char_class)
  );

  assign chars.ready = !queue_full;

  // Decoupling queue.
  aup_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (chars.valid),
    .push_data (char_class),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (head_valid),
    .head      (head)
  );

  // Accumulator and result register.
  aup_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .parsed_value (result.parsed_value),
    .ok           (result.ok)
  );

endmodule

`default_nettype wire

[hdl/aup_checker.sv]
// ----------------------------------------------------------------------------
// aup_checker
// Port-level checks on the parser, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ascii_unsigned_integer_parser_top_macros.svh"

module aup_checker #(
  parameter int VALUE_WIDTH = aup_pkg::VALUE_WIDTH_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [VALUE_WIDTH-1:0] out_value,
  input wire logic                   out_ok
);

  // A held result keeps its payload.
  `AUP_ASSERT_NEXT(a_result_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_ok), "result changed while stalled")

  // A failed parse always reports zero.
  `AUP_ASSERT_SAME(a_fail_zero, clk, rst, out_valid && !out_ok, out_value == '0, "failed result has nonzero value")

  // No result right after reset.
  `AUP_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !out_valid, "result valid after reset")

  // The queue only fills through accepted items.
  `AUP_ASSERT_SAME(a_ready_drop, clk, rst, $fell(in_ready), $past(in_valid), "ready dropped with no item offered")

endmodule

bind ascii_unsigned_integer_parser_top aup_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_aup_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (chars.valid),
  .in_ready  (chars.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_value (result.parsed_value),
  .out_ok    (result.ok)
);

`default_nettype wire
